[hdl/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the comment and string blanker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define CSB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define CSB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/csb_pkg.sv]
// Package: types, character codes and helpers for the comment and string blanker.
`timescale 1ns / 1ps
package csb_pkg;

  // Lexer modes
  typedef enum logic [2:0] {
    MODE_PLAIN = 3'd0,
    MODE_LINE  = 3'd1,
    MODE_BLOCK = 3'd2,
    MODE_STR   = 3'd3,
    MODE_ESC   = 3'd4
  } lex_mode_t;

  // End-of-text status codes
  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_BLOCK = 2'd1,
    ERR_STR   = 2'd2
  } err_code_t;

  // Configuration register indexes
  localparam logic CFG_BLANK_COMMENTS = 1'b0;
  localparam logic CFG_BLANK_STRINGS  = 1'b1;

  // Character codes
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_QUOTE  = 8'h22;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_SLASH  = 8'h2F;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;

  // Result queue depth: one waiting result plus a full pair
  localparam int QUEUE_DEPTH = 3;

  typedef struct packed {
    logic blank_comments;
    logic blank_strings;
  } cfg_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
    logic       text_done;
    err_code_t  error_code;
  } res_t;

  // Results produced by one input item
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } lex_out_t;

  // Whitespace: space, or TAB through CR
  function automatic logic is_ws(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

endpackage

[hdl/csb_lexer.sv]
// Lexer state registers and per-item result decode for the blanker.
`timescale 1ns / 1ps
module csb_lexer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        in_char,
  input  logic              end_of_text,
  input  csb_pkg::cfg_t     cfg,
  output csb_pkg::lex_out_t lex_out
);
  import csb_pkg::*;

  lex_mode_t  mode_r, mode_nxt;
  logic       held_r, held_nxt;
  logic       star_r, star_nxt;
  logic [7:0] c;
  logic [7:0] ch0, ch1;
  logic [1:0] n;
  err_code_t  err;

  // Next state and result characters
  always_comb begin
    c        = (in_char == CHAR_CR) ? CHAR_SPACE : in_char;
    mode_nxt = mode_r;
    held_nxt = held_r;
    star_nxt = star_r;
    ch0      = c;
    ch1      = c;
    n        = 2'd1;
    err      = ERR_OK;
    unique case (mode_r)
      MODE_LINE: begin
        if (c == CHAR_LF) begin
          mode_nxt = MODE_PLAIN;
        end else if (cfg.blank_comments) begin
          ch0 = CHAR_SPACE;
        end
      end
      MODE_BLOCK: begin
        // the star of the opener never counts as a closing candidate
        if (star_r && (c == CHAR_SLASH)) begin
          mode_nxt = MODE_PLAIN;
          star_nxt = 1'b0;
        end else begin
          star_nxt = (c == CHAR_STAR);
        end
        if (cfg.blank_comments && !is_ws(c)) ch0 = CHAR_SPACE;
      end
      MODE_STR: begin
        if (c == CHAR_QUOTE) begin
          mode_nxt = MODE_PLAIN;
        end else begin
          if (c == CHAR_BSLASH) mode_nxt = MODE_ESC;
          if (cfg.blank_strings) ch0 = CHAR_SPACE;
        end
      end
      MODE_ESC: begin
        mode_nxt = MODE_STR;
        if (cfg.blank_strings) ch0 = CHAR_SPACE;
      end
      default: begin
        mode_nxt = MODE_PLAIN;
        if (held_r) begin
          held_nxt = 1'b0;
          n        = 2'd2;
          if ((c == CHAR_SLASH) || (c == CHAR_STAR)) begin
            mode_nxt = (c == CHAR_SLASH) ? MODE_LINE : MODE_BLOCK;
            star_nxt = 1'b0;
            ch0      = cfg.blank_comments ? CHAR_SPACE : CHAR_SLASH;
            ch1      = cfg.blank_comments ? CHAR_SPACE : c;
          end else begin
            ch0 = CHAR_SLASH;
            if (c == CHAR_QUOTE) mode_nxt = MODE_STR;
          end
        end else if (c == CHAR_QUOTE) begin
          mode_nxt = MODE_STR;
        end else if (c == CHAR_SLASH) begin
          held_nxt = 1'b1;
          n        = 2'd0;
        end
      end
    endcase

    // end of text: release a held slash, report open constructs, restart
    if (end_of_text) begin
      if (held_nxt) begin
        ch0 = CHAR_SLASH;
        n   = 2'd1;
      end
      if (mode_nxt == MODE_BLOCK) begin
        err = ERR_BLOCK;
      end else if ((mode_nxt == MODE_STR) || (mode_nxt == MODE_ESC)) begin
        err = ERR_STR;
      end
      mode_nxt = MODE_PLAIN;
      held_nxt = 1'b0;
      star_nxt = 1'b0;
    end
  end

  // Result records; flags go on the last one
  always_comb begin
    lex_out.count             = n;
    lex_out.first.out_char    = ch0;
    lex_out.first.run_last    = (n == 2'd1);
    lex_out.first.text_done   = (n == 2'd1) && end_of_text;
    lex_out.first.error_code  = ((n == 2'd1) && end_of_text) ? err : ERR_OK;
    lex_out.second.out_char   = ch1;
    lex_out.second.run_last   = 1'b1;
    lex_out.second.text_done  = end_of_text;
    lex_out.second.error_code = end_of_text ? err : ERR_OK;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PLAIN;
      held_r <= 1'b0;
      star_r <= 1'b0;
    end else if (step) begin
      mode_r <= mode_nxt;
      held_r <= held_nxt;
      star_r <= star_nxt;
    end
  end

endmodule

[hdl/comment_string_blanker.sv]
// Top level: streaming C-style comment and string blanker.
//
//  port group | dir | payload                                   | handshake
//  in_        | in  | tdata[7:0] char, tlast end of text         | tvalid/tready
//  out_       | out | tdata[7:0] char, tlast run last, tuser     | tvalid/tready
//  cfg_       | in  | addr selects register, wdata[0] value      | we only
//
// One item is accepted per cycle while the result queue holds at most one entry.
// Each item yields zero, one or two results, registered into the queue; a result pair
// drains one result at a time through the single out_ port, which sets the rate for pairs.
// Reset (rst_n low, synchronous) empties the queue and returns the lexer to
// plain text with blank_comments set and blank_strings clear.
// out_tready low fills the three-entry queue; in_tready drops once two results wait.
`timescale 1ns / 1ps
module comment_string_blanker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_char
  input  logic       in_tlast,   // end_of_text
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic       out_tlast,  // run_last
  output logic [2:0] out_tuser,  // [0] text_done, [2:1] error_code
  input  logic       cfg_we,
  input  logic       cfg_addr,
  input  logic       cfg_wdata
);
  import csb_pkg::*;
  `include "assert_macros.svh"

  cfg_t       cfg_r;
  lex_out_t   lex_out;
  res_t       q_r   [QUEUE_DEPTH];
  res_t       q_nxt [QUEUE_DEPTH];
  logic [1:0] q_cnt_r, q_cnt_nxt;
  logic [1:0] base;
  logic       push, pop;

  assign push = in_tvalid && in_tready;
  assign pop  = out_tvalid && out_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.blank_comments <= 1'b1;
      cfg_r.blank_strings  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_BLANK_COMMENTS: cfg_r.blank_comments <= cfg_wdata;
        CFG_BLANK_STRINGS:  cfg_r.blank_strings  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  csb_lexer u_lexer (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (push),
    .in_char     (in_tdata),
    .end_of_text (in_tlast),
    .cfg         (cfg_r),
    .lex_out     (lex_out)
  );

  // Result queue: head at slot 0, shifts down on each pop
  assign in_tready = (q_cnt_r < 2'd2);
  assign base      = q_cnt_r - {1'b0, pop};

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q_nxt[i] = q_r[i];
    end
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      if (pop) q_nxt[i] = q_r[i + 1];
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (push && (lex_out.count != 2'd0) && (2'(i) == base)) begin
        q_nxt[i] = lex_out.first;
      end
      if (push && (lex_out.count == 2'd2) && (2'(i) == base + 2'd1)) begin
        q_nxt[i] = lex_out.second;
      end
    end
    q_cnt_nxt = base + (push ? lex_out.count : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= 2'd0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  // Output drive from the queue head
  assign out_tvalid = (q_cnt_r != 2'd0);
  assign out_tdata  = q_r[0].out_char;
  assign out_tlast  = q_r[0].run_last;
  assign out_tuser  = {q_r[0].error_code, q_r[0].text_done};

  // Checks
  `CSB_ASSERT(a_done_is_last, (out_tvalid && out_tuser[0]) |-> out_tlast, "text_done without run_last")
  `CSB_ASSERT(a_err_with_done, (out_tvalid && (out_tuser[2:1] != 2'd0)) |-> out_tuser[0], "error code outside text end")
  `CSB_ASSERT(a_eot_gives_result, (push && in_tlast) |-> (lex_out.count != 2'd0), "end of text produced no result")
  `CSB_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (q_cnt_r == 2'd0), "queue not empty after reset")

endmodule

[test/blanker_checker.sv]
// Checker for the comment and string blanker: predicts each result and compares it.
`timescale 1ns / 1ps
module blanker_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_char
  input  logic       in_tlast,   // end_of_text
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // [7:0] out_char
  input  logic       out_tlast,  // run_last
  input  logic [2:0] out_tuser,  // [0] text_done, [2:1] error_code
  input  logic       cfg_we,
  input  logic       cfg_addr,
  input  logic       cfg_wdata,
  input  logic       drain_done,
  output int         fail_count,
  output int         pending
);
  import csb_pkg::*;

  // Shadow of the lexer state and registers
  lex_mode_t lex_st;
  logic      slash_held;
  logic      star_seen;
  logic      cmt_blank;
  logic      str_blank;
  logic      drain_seen;
  res_t      pending_out[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report(input string msg);
    fail_count++;
    if (fail_count <= 40) $display("%0t ns mismatch: %s", $time, msg);
  endtask

  // Work out the results that one item causes and queue them
  task automatic blank_byte(input logic [7:0] raw, input logic eot);
    logic [7:0] c;
    logic [7:0] chars[$];
    err_code_t  err;
    res_t       r;
    bit         last;
    c   = (raw == CHAR_CR) ? CHAR_SPACE : raw;
    err = ERR_OK;
    case (lex_st)
      MODE_LINE: begin
        if (c == CHAR_LF) begin
          lex_st = MODE_PLAIN;
          chars.push_back(c);
        end else begin
          chars.push_back(cmt_blank ? CHAR_SPACE : c);
        end
      end
      MODE_BLOCK: begin
        if (star_seen && c == CHAR_SLASH) begin
          lex_st    = MODE_PLAIN;
          star_seen = 1'b0;
        end else begin
          star_seen = (c == CHAR_STAR);
        end
        // whitespace survives blanking inside block comments
        chars.push_back((cmt_blank && !(c inside {[CHAR_TAB:CHAR_CR], CHAR_SPACE})) ?
                        CHAR_SPACE : c);
      end
      MODE_STR: begin
        if (c == CHAR_QUOTE) begin
          lex_st = MODE_PLAIN;
          chars.push_back(c);
        end else begin
          if (c == CHAR_BSLASH) lex_st = MODE_ESC;
          chars.push_back(str_blank ? CHAR_SPACE : c);
        end
      end
      MODE_ESC: begin
        lex_st = MODE_STR;
        chars.push_back(str_blank ? CHAR_SPACE : c);
      end
      default: begin
        if (slash_held && (c == CHAR_SLASH || c == CHAR_STAR)) begin
          // comment opens; its opening star cannot close it
          slash_held = 1'b0;
          lex_st     = (c == CHAR_SLASH) ? MODE_LINE : MODE_BLOCK;
          star_seen  = 1'b0;
          chars.push_back(cmt_blank ? CHAR_SPACE : CHAR_SLASH);
          chars.push_back(cmt_blank ? CHAR_SPACE : c);
        end else begin
          if (slash_held) begin
            slash_held = 1'b0;
            chars.push_back(CHAR_SLASH);
          end
          if (c == CHAR_QUOTE) begin
            lex_st = MODE_STR;
            chars.push_back(c);
          end else if (c == CHAR_SLASH) begin
            slash_held = 1'b1;
          end else begin
            chars.push_back(c);
          end
        end
      end
    endcase

    // end of text: flush a held slash, report what is still open
    if (eot) begin
      if (slash_held) chars.push_back(CHAR_SLASH);
      if (lex_st == MODE_BLOCK) err = ERR_BLOCK;
      else if (lex_st == MODE_STR || lex_st == MODE_ESC) err = ERR_STR;
      lex_st     = MODE_PLAIN;
      slash_held = 1'b0;
      star_seen  = 1'b0;
    end

    foreach (chars[k]) begin
      last         = (k == chars.size() - 1);
      r.out_char   = chars[k];
      r.run_last   = last;
      r.text_done  = last && eot;
      r.error_code = (last && eot) ? err : ERR_OK;
      pending_out.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    res_t e;
    if (!rst_n) begin
      lex_st     = MODE_PLAIN;
      slash_held = 1'b0;
      star_seen  = 1'b0;
      cmt_blank  = 1'b1;
      str_blank  = 1'b0;
      drain_seen = 1'b0;
      pending_out.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        if (cfg_addr == CFG_BLANK_COMMENTS) cmt_blank = cfg_wdata;
        else                                str_blank = cfg_wdata;
      end

      // compare a result against the oldest expectation
      if (out_tvalid && out_tready) begin
        if (pending_out.size() == 0) begin
          report($sformatf("unexpected result char=%02h last=%b user=%03b",
                           out_tdata, out_tlast, out_tuser));
        end else begin
          e = pending_out.pop_front();
          if (out_tdata !== e.out_char)
            report($sformatf("out_char got %02h, want %02h", out_tdata, e.out_char));
          if (out_tlast !== e.run_last)
            report($sformatf("run_last got %b, want %b (char %02h)",
                             out_tlast, e.run_last, e.out_char));
          if (out_tuser[0] !== e.text_done)
            report($sformatf("text_done got %b, want %b (char %02h)",
                             out_tuser[0], e.text_done, e.out_char));
          if (out_tuser[2:1] !== e.error_code)
            report($sformatf("error_code got %0d, want %0d (char %02h)",
                             out_tuser[2:1], e.error_code, e.out_char));
        end
      end

      // predict results of an accepted item
      if (in_tvalid && in_tready) blank_byte(in_tdata, in_tlast);

      if (drain_done && !drain_seen) begin
        drain_seen = 1'b1;
        if (pending_out.size() != 0)
          report($sformatf("%0d results never arrived", pending_out.size()));
      end
    end
    pending <= pending_out.size();
  end

endmodule

[test/tb_top.sv]
// Testbench top for the comment and string blanker: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_top;
  import csb_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 100;
  localparam bit MODE_BC[5]   = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
  localparam bit MODE_BS[5]   = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic [2:0] out_tuser;
  logic       cfg_we     = 1'b0;
  logic       cfg_addr   = 1'b0;
  logic       cfg_wdata  = 1'b0;
  logic       drain_done = 1'b0;
  int         fail_count;
  int         pending;

  bit gaps_on    = 1'b1;
  bit stalls_on  = 1'b1;
  int hold_reqs  = 0;
  int holds_done = 0;
  int items      = 0;

  comment_string_blanker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  blanker_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .drain_done (drain_done),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int gap_len(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one item and wait until it is taken
  task automatic send_item(input logic [7:0] c, input logic eot);
    int g;
    g = gap_len(gaps_on);
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= eot;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // Random bytes end the text now and then, often inside a comment or string
  task automatic send_byte(input logic [7:0] c);
    send_item(c, $urandom_range(0, 39) == 0);
  endtask

  function automatic logic [7:0] special_byte();
    case ($urandom_range(0, 6))
      0:       return CHAR_SLASH;
      1:       return CHAR_STAR;
      2:       return CHAR_QUOTE;
      3:       return CHAR_BSLASH;
      4:       return CHAR_LF;
      5:       return CHAR_CR;
      default: return CHAR_TAB;
    endcase
  endfunction

  function automatic logic [7:0] word_byte();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(8'h30, 8'h39)) :
                                         8'($urandom_range(8'h61, 8'h7A));
  endfunction

  // One lexical piece: mostly well-formed, some noise
  task automatic send_token();
    int n;
    case ($urandom_range(0, 11))
      0, 1: begin
        n = $urandom_range(1, 6);
        repeat (n) send_byte(word_byte());
      end
      2: send_byte(($urandom_range(0, 1) == 0) ? CHAR_SPACE : special_byte());
      3: begin
        // line comment
        send_byte(CHAR_SLASH);
        send_byte(CHAR_SLASH);
        n = $urandom_range(0, 8);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) send_byte(8'($urandom_range(0, 255)));
          else                           send_byte(word_byte());
        end
        send_byte(CHAR_LF);
      end
      4, 5: begin
        // block comment with stars, slashes and whitespace inside
        send_byte(CHAR_SLASH);
        send_byte(CHAR_STAR);
        n = $urandom_range(0, 10);
        repeat (n) begin
          case ($urandom_range(0, 4))
            0:       send_byte(CHAR_STAR);
            1:       send_byte(special_byte());
            2:       send_byte(8'($urandom_range(0, 255)));
            default: send_byte(word_byte());
          endcase
        end
        send_byte(CHAR_STAR);
        send_byte(CHAR_SLASH);
      end
      6, 7: begin
        // string with escape pairs
        send_byte(CHAR_QUOTE);
        n = $urandom_range(0, 8);
        repeat (n) begin
          if ($urandom_range(0, 4) == 0) begin
            send_byte(CHAR_BSLASH);
            send_byte(($urandom_range(0, 1) == 0) ? special_byte() :
                                                    8'($urandom_range(0, 255)));
          end else begin
            send_byte(word_byte());
          end
        end
        send_byte(CHAR_QUOTE);
      end
      8: begin
        // lone slash before something other than a comment opener
        send_byte(CHAR_SLASH);
        case ($urandom_range(0, 2))
          0:       send_byte(CHAR_QUOTE);
          1:       send_byte(CHAR_SPACE);
          default: send_byte(word_byte());
        endcase
      end
      9:  send_byte(special_byte());
      10: send_byte(8'($urandom_range(8'h80, 8'hFF)));
      default: send_byte(8'($urandom_range(0, 255)));
    endcase
  endtask

  // Write both registers once every expected result is out
  task automatic set_mode(input logic bc, input logic bs);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_BLANK_COMMENTS;
    cfg_wdata <= bc;
    @(posedge clk);
    cfg_addr  <= CFG_BLANK_STRINGS;
    cfg_wdata <= bs;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Receiver: random stalls, plus long hold-offs on request
  initial begin : sink
    int n;
    wait (rst_n === 1'b1);
    forever begin
      if (holds_done != hold_reqs) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        n = gap_len(stalls_on);
        if (n > 0) begin
          out_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stim
    int start;
    bit held;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed text under reset settings
    send_text("//");                     // line comment, CR inside, newline ends it
    send_item(CHAR_CR, 1'b0);
    send_item(CHAR_LF, 1'b0);
    send_text("/*/**/");                 // opening star does not close
    send_text("\"\\\"\"");               // escaped quote inside a string
    send_text("/q/\"");                  // released slashes, string opens
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(CHAR_BSLASH, 1'b1);        // text ends inside a string escape
    send_item(CHAR_SLASH, 1'b0);
    send_item(CHAR_STAR, 1'b1);          // text ends in an open block comment
    send_item(CHAR_SLASH, 1'b1);         // held slash flushed at end of text

    // Random phases across register settings
    for (int ph = 0; ph < 5; ph++) begin
      set_mode(MODE_BC[ph], MODE_BS[ph]);
      gaps_on   = (ph != 1);
      stalls_on = (ph != 1);
      start     = items;
      held      = 1'b0;
      while (items - start < PHASE_ITEMS) begin
        // back-pressure: receiver holds off while items keep coming
        if (ph == 1 && !held && items - start >= 40) begin
          held = 1'b1;
          hold_reqs++;
        end
        send_token();
      end
      send_item(8'($urandom_range(0, 255)), 1'b1);
    end

    // Drain and decide
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/csb_pkg.sv
hdl/csb_lexer.sv
hdl/comment_string_blanker.sv
test/blanker_checker.sv
test/tb_top.sv
